// ----- design/sts_pkg.sv -----
package sts_pkg;

   // payload widths fixed by the item format
   localparam int SUM_W = 64;
   localparam int VAL_W = 32;

   // request kinds
   localparam logic REQ_SET = 1'b0;
   localparam logic REQ_SUM = 1'b1;

   typedef enum logic [7:0] {
      ST_CLEAR     = 8'b0000_0001,
      ST_IDLE      = 8'b0000_0010,
      ST_SET_DOWN  = 8'b0000_0100,
      ST_SET_UP    = 8'b0000_1000,
      ST_SUM_TOP   = 8'b0001_0000,
      ST_SUM_LEFT  = 8'b0010_0000,
      ST_SUM_RIGHT = 8'b0100_0000,
      ST_SUM_DONE  = 8'b1000_0000
   } walk_state_type;

endpackage

// ----- design/sts_node_ram.sv -----
module sts_node_ram #(
   parameter int MAX_POSITIONS = 1024,
   localparam int NODE_DEPTH = 4 * MAX_POSITIONS,
   localparam int NODE_W = $clog2(NODE_DEPTH)
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [NODE_W-1:0]        wr_addr,
   input  logic [sts_pkg::SUM_W-1:0] wr_data,
   input  logic                     rd_en,
   input  logic [NODE_W-1:0]        rd_addr,
   output logic [sts_pkg::SUM_W-1:0] rd_data
);
   import sts_pkg::*;

   logic [SUM_W-1:0] mem_ff [NODE_DEPTH];
   logic [SUM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/sts_walker.sv -----
module sts_walker #(
   parameter int MAX_POSITIONS = 1024,
   localparam int POS_W = $clog2(MAX_POSITIONS + 1),
   localparam int NODE_DEPTH = 4 * MAX_POSITIONS,
   localparam int NODE_W = $clog2(NODE_DEPTH)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_type,
   input  logic [POS_W-1:0]                 req_position,
   input  logic signed [sts_pkg::VAL_W-1:0] req_new_value,
   input  logic [POS_W-1:0]                 req_range_low,
   input  logic [POS_W-1:0]                 req_range_high,
   input  logic [POS_W-1:0]                 eff_size,
   output logic                             rsp_valid,
   output logic signed [sts_pkg::SUM_W-1:0] rsp_range_sum,
   output logic                             mem_wr_en,
   output logic [NODE_W-1:0]                mem_wr_addr,
   output logic [sts_pkg::SUM_W-1:0]        mem_wr_data,
   output logic                             mem_rd_en,
   output logic [NODE_W-1:0]                mem_rd_addr,
   input  logic [sts_pkg::SUM_W-1:0]        mem_rd_data
);
   import sts_pkg::*;

   localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODE_DEPTH - 1);
   localparam logic [NODE_W-1:0] ROOT      = NODE_W'(1);
   localparam logic [POS_W-1:0]  FIRST_POS = POS_W'(1);

   walk_state_type   state_ff, state_in;
   logic [NODE_W-1:0] clr_ff, clr_in;
   logic [NODE_W-1:0] k_ff, k_in;
   logic [POS_W-1:0]  lo_ff, lo_in, hi_ff, hi_in;
   logic [POS_W-1:0]  a_ff, a_in, b_ff, b_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [NODE_W-1:0] rk_ff, rk_in;
   logic [POS_W-1:0]  rlo_ff, rlo_in, rhi_ff, rhi_in;
   logic [SUM_W-1:0]  carry_ff, carry_in;
   logic [SUM_W-1:0]  acc_ff, acc_in;
   logic              rd_pend_ff, rd_pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]  rsp_sum_ff, rsp_sum_in;

   logic [POS_W:0]    mid_sum;
   logic [POS_W-1:0]  mid;
   logic [NODE_W-1:0] k_left, k_right, k_parent, k_sib, parent_sib;
   logic [POS_W-1:0]  a_clip, b_clip;
   logic [SUM_W-1:0]  up_sum;

   always_comb begin
      mid_sum    = {1'b0, lo_ff} + {1'b0, hi_ff};
      mid        = mid_sum[POS_W:1];
      k_left     = {k_ff[NODE_W-2:0], 1'b0};
      k_right    = {k_ff[NODE_W-2:0], 1'b1};
      k_parent   = {1'b0, k_ff[NODE_W-1:1]};
      k_sib      = {k_ff[NODE_W-1:1], ~k_ff[0]};
      parent_sib = {k_parent[NODE_W-1:1], ~k_parent[0]};
      a_clip     = (req_range_low == '0) ? FIRST_POS : req_range_low;
      b_clip     = (req_range_high > eff_size) ? eff_size : req_range_high;
      up_sum     = carry_ff + mem_rd_data;
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      k_in         = k_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      pos_in       = pos_ff;
      rk_in        = rk_ff;
      rlo_in       = rlo_ff;
      rhi_in       = rhi_ff;
      carry_in     = carry_ff;
      acc_in       = acc_ff + (rd_pend_ff ? mem_rd_data : '0);
      rd_pend_in   = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_sum_in   = rsp_sum_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = k_ff;
      mem_wr_data  = carry_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = k_ff;

      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            mem_wr_data = '0;
            clr_in      = clr_ff + NODE_W'(1);
            if (clr_ff == LAST_NODE) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               k_in   = ROOT;
               lo_in  = FIRST_POS;
               hi_in  = eff_size;
               acc_in = '0;
               if (req_type == REQ_SET) begin
                  pos_in   = req_position;
                  carry_in = {{(SUM_W - VAL_W){req_new_value[VAL_W-1]}}, req_new_value};
                  if (req_position != '0 && req_position <= eff_size) begin
                     state_in = ST_SET_DOWN;
                  end
               end else begin
                  a_in = a_clip;
                  b_in = b_clip;
                  if (a_clip > b_clip) begin
                     state_in = ST_SUM_DONE;
                  end else begin
                     state_in = ST_SUM_TOP;
                  end
               end
            end
         end
         ST_SET_DOWN: begin
            if (lo_ff == hi_ff) begin
               // leaf: store the value, fetch the sibling for the climb
               mem_wr_en   = 1'b1;
               mem_wr_addr = k_ff;
               mem_wr_data = carry_ff;
               if (k_ff == ROOT) begin
                  state_in = ST_IDLE;
               end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = k_sib;
                  state_in    = ST_SET_UP;
               end
            end else if (pos_ff <= mid) begin
               k_in  = k_left;
               hi_in = mid;
            end else begin
               k_in  = k_right;
               lo_in = mid + FIRST_POS;
            end
         end
         ST_SET_UP: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = k_parent;
            mem_wr_data = up_sum;
            carry_in    = up_sum;
            k_in        = k_parent;
            if (k_parent == ROOT) begin
               state_in = ST_IDLE;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = parent_sib;
            end
         end
         ST_SUM_TOP: begin
            if (a_ff <= lo_ff && hi_ff <= b_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = k_ff;
               rd_pend_in  = 1'b1;
               state_in    = ST_SUM_DONE;
            end else if (b_ff <= mid) begin
               k_in  = k_left;
               hi_in = mid;
            end else if (a_ff > mid) begin
               k_in  = k_right;
               lo_in = mid + FIRST_POS;
            end else begin
               // split node: walk the left edge now, keep the right child
               rk_in    = k_right;
               rlo_in   = mid + FIRST_POS;
               rhi_in   = hi_ff;
               k_in     = k_left;
               hi_in    = mid;
               state_in = ST_SUM_LEFT;
            end
         end
         ST_SUM_LEFT: begin
            if (a_ff <= lo_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = k_ff;
               rd_pend_in  = 1'b1;
               k_in        = rk_ff;
               lo_in       = rlo_ff;
               hi_in       = rhi_ff;
               state_in    = ST_SUM_RIGHT;
            end else if (a_ff <= mid) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = k_right;
               rd_pend_in  = 1'b1;
               k_in        = k_left;
               hi_in       = mid;
            end else begin
               k_in  = k_right;
               lo_in = mid + FIRST_POS;
            end
         end
         ST_SUM_RIGHT: begin
            if (hi_ff <= b_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = k_ff;
               rd_pend_in  = 1'b1;
               state_in    = ST_SUM_DONE;
            end else if (b_ff > mid) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = k_left;
               rd_pend_in  = 1'b1;
               k_in        = k_right;
               lo_in       = mid + FIRST_POS;
            end else begin
               k_in  = k_left;
               hi_in = mid;
            end
         end
         ST_SUM_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_sum_in   = acc_in;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff       <= k_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      pos_ff     <= pos_in;
      rk_ff      <= rk_in;
      rlo_ff     <= rlo_in;
      rhi_ff     <= rhi_in;
      carry_ff   <= carry_in;
      acc_ff     <= acc_in;
      rsp_sum_ff <= rsp_sum_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_range_sum = rsp_sum_ff;

   // a result beat follows only the closing step of a sum walk
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ST_SUM_DONE))
      else $error("result beat without a finished sum walk");

   // read data is only folded in when a read went out the cycle before
   a_pend_has_read: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> $past(mem_rd_en))
      else $error("accumulate without a read");

   // the climb never sits on the root
   a_climb_not_root: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SET_UP) |-> (k_ff != ROOT))
      else $error("climb reached past the root");

   // an idle walker leaves the node store alone
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !mem_wr_en)
      else $error("node write while idle");

endmodule

// ----- design/segment_tree_range_sum.sv -----
// set beat: walks down from the root to the leaf, then climbs back up refreshing each
//   parent sum on the way; an ignored set keeps busy low
// sum beat: result strobe follows the walk, at most one node read per level on each
//   range edge; an empty range goes straight to the closing step
// throughput: one beat at a time, a start is taken only while busy is low; results cannot be stalled
// reset: synchronous; busy high through a clear of all 4*MAX_POSITIONS node store entries
module segment_tree_range_sum #(
   parameter int MAX_POSITIONS = 1024,
   localparam int POS_W = $clog2(MAX_POSITIONS + 1),
   localparam int NODE_W = $clog2(4 * MAX_POSITIONS)
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_type,
   input  logic [POS_W-1:0]                 req_position,
   input  logic signed [sts_pkg::VAL_W-1:0] req_new_value,
   input  logic [POS_W-1:0]                 req_range_low,
   input  logic [POS_W-1:0]                 req_range_high,
   // result channel, one beat per sum request
   output logic                             rsp_valid,
   output logic signed [sts_pkg::SUM_W-1:0] rsp_range_sum,
   // active size register
   input  logic                             csr_we,
   input  logic [POS_W-1:0]                 csr_wdata
);
   import sts_pkg::*;

   localparam logic [POS_W-1:0] SIZE_MAX = POS_W'(MAX_POSITIONS);

   logic [POS_W-1:0]  active_size_ff;
   logic [POS_W-1:0]  eff_size;

   // node store port
   logic              mem_wr_en;
   logic [NODE_W-1:0] mem_wr_addr;
   logic [SUM_W-1:0]  mem_wr_data;
   logic              mem_rd_en;
   logic [NODE_W-1:0] mem_rd_addr;
   logic [SUM_W-1:0]  mem_rd_data;

   // size register, writable at any time including the clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         active_size_ff <= SIZE_MAX;
      end else if (csr_we) begin
         active_size_ff <= csr_wdata;
      end
   end

   // zero acts as one, anything above the store capacity acts as the capacity
   always_comb begin
      if (active_size_ff == '0) begin
         eff_size = POS_W'(1);
      end else if (active_size_ff > SIZE_MAX) begin
         eff_size = SIZE_MAX;
      end else begin
         eff_size = active_size_ff;
      end
   end

   // tree walker: clearing sweep, point set with sum refresh, range sum
   sts_walker #(
      .MAX_POSITIONS (MAX_POSITIONS)
   ) u_walker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_position   (req_position),
      .req_new_value  (req_new_value),
      .req_range_low  (req_range_low),
      .req_range_high (req_range_high),
      .eff_size       (eff_size),
      .rsp_valid      (rsp_valid),
      .rsp_range_sum  (rsp_range_sum),
      .mem_wr_en      (mem_wr_en),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_data    (mem_wr_data),
      .mem_rd_en      (mem_rd_en),
      .mem_rd_addr    (mem_rd_addr),
      .mem_rd_data    (mem_rd_data)
   );

   // node sums, heap-indexed with the root at 1, registered read
   sts_node_ram #(
      .MAX_POSITIONS (MAX_POSITIONS)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule
